[design/tlbcc_pkg.sv]
// Shared types and constants for the two-level bitmap character-class engine.
// Depends on nothing; the input interface, the mask unit and the top import it.
package tlbcc_pkg;

  // Code point layout: bits 20:8 pick the page, 7:5 the word, 4:0 the bit.
  localparam int unsigned CP_W         = 21;
  localparam int unsigned OFFSET_SHIFT = 8;
  localparam int unsigned BITSET_SHIFT = 5;
  localparam int unsigned PAGE_IDX_W   = CP_W - OFFSET_SHIFT;
  localparam int unsigned WORD_SEL_W   = OFFSET_SHIFT - BITSET_SHIFT;
  localparam int unsigned BIT_SEL_W    = BITSET_SHIFT;
  localparam int unsigned WORD_W       = 32;

  localparam logic [WORD_SEL_W-1:0] WORD_LAST = '1;

  // Operation codes of an input item.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // One request to the word mask unit: the range and the word it covers.
  typedef struct packed {
    logic [CP_W-1:0]       first;
    logic [CP_W-1:0]       last;
    logic [PAGE_IDX_W-1:0] page;
    logic [WORD_SEL_W-1:0] word;
  } word_req_t;

endpackage

[design/tlbcc_in_if.sv]
// Input channel of the character-class engine: valid, ready and one item.
// Depends on tlbcc_pkg for the field widths.
interface tlbcc_in_if;
  import tlbcc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [CP_W-1:0]       range_first;
  logic [CP_W-1:0]       range_last;
  logic [CP_W-1:0]       query_char;

  modport source (output valid, output op, output range_first, output range_last,
                  output query_char, input ready);
  modport sink (input valid, input op, input range_first, input range_last,
                input query_char, output ready);
endinterface

[design/tlbcc_out_if.sv]
// Result channel of the character-class engine: valid, ready and one item.
// Depends on nothing.
interface tlbcc_out_if;
  logic valid;
  logic ready;
  logic is_member;
  logic status;

  modport source (output valid, output is_member, output status, input ready);
  modport sink (input valid, input is_member, input status, output ready);
endinterface

[design/tlbcc_mask_unit.sv]
// Shared mask unit: the bits of one bitmap word that fall inside a range.
// Depends on tlbcc_pkg.
module tlbcc_mask_unit (
  input  tlbcc_pkg::word_req_t          req_i,
  output logic [tlbcc_pkg::WORD_W-1:0]  mask_o
);
  import tlbcc_pkg::*;

  logic [CP_W-1:0]      word_lo;
  logic [CP_W-1:0]      word_hi;
  logic                 empty;
  logic [BIT_SEL_W-1:0] lo_bit;
  logic [BIT_SEL_W-1:0] hi_bit;

  // Code points covered by the word, and the range clipped to them.
  always_comb begin
    word_lo = {req_i.page, req_i.word, {BIT_SEL_W{1'b0}}};
    word_hi = {req_i.page, req_i.word, {BIT_SEL_W{1'b1}}};
    empty   = (req_i.first > word_hi) || (req_i.last < word_lo);
    lo_bit  = (req_i.first < word_lo) ? '0 : req_i.first[BIT_SEL_W-1:0];
    hi_bit  = (req_i.last > word_hi) ? '1 : req_i.last[BIT_SEL_W-1:0];
  end

  // Ones from the low bit up, anded with ones from the high bit down.
  always_comb begin
    if (empty) begin
      mask_o = '0;
    end else begin
      mask_o = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
    end
  end
endmodule

[design/two_level_bitmap_char_class_top.sv]
// Two-level bitmap character-class engine: page map plus 256-bit bitmaps, one item at a time.
// Query: page map read, bitmap word read and bit pick, then the output register. Add: for each
// page reached, a page map read and check, then a read and a write of each of 8 bitmap words
// through one mask unit; a page that finds the store full ends the add. Clear: one page map
// entry of the written span is zeroed per cycle. After reset a sweep zeroes the page map; no
// item is taken until it ends. A stalled result holds the next one back in S_DONE.
module two_level_bitmap_char_class_top #(
  parameter int unsigned PAGE_COUNT   = 8192,
  parameter int unsigned BITMAP_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlbcc_in_if.sink    in_i,
  tlbcc_out_if.source out_o
);
  import tlbcc_pkg::*;

  localparam int unsigned PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned SLOT_W  = $clog2(BITMAP_COUNT);
  localparam int unsigned BM_AW   = SLOT_W + WORD_SEL_W;
  localparam int unsigned BM_DEPTH = BITMAP_COUNT << WORD_SEL_W;
  localparam logic [PAGE_IDX_W:0]   PageLimit = (PAGE_IDX_W + 1)'(PAGE_COUNT);
  localparam logic [PAGE_IDX_W-1:0] PageMax   = PAGE_IDX_W'(PAGE_COUNT - 1);
  localparam logic [SLOT_W-1:0]     UsedMax   = SLOT_W'(BITMAP_COUNT - 1);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_ADD_PM  = 4'd2;
  localparam logic [3:0] S_ADD_CHK = 4'd3;
  localparam logic [3:0] S_ADD_RD  = 4'd4;
  localparam logic [3:0] S_ADD_WR  = 4'd5;
  localparam logic [3:0] S_Q_PM    = 4'd6;
  localparam logic [3:0] S_Q_BM    = 4'd7;
  localparam logic [3:0] S_Q_BIT   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  // Control registers.
  logic [3:0]            state_q, state_d;
  logic [SLOT_W-1:0]     used_q, used_d;
  logic [PAGE_IDX_W-1:0] low_q, low_d;
  logic [PAGE_IDX_W-1:0] high_q, high_d;
  logic                  any_q, any_d;
  logic [PAGE_IDX_W-1:0] clr_ptr_q, clr_ptr_d;
  logic [PAGE_IDX_W-1:0] clr_end_q, clr_end_d;
  logic                  clr_reply_q, clr_reply_d;
  logic                  out_valid_q, out_valid_d;

  // Payload and work registers.
  logic [CP_W-1:0]       first_q, first_d;
  logic [CP_W-1:0]       last_q, last_d;
  logic [CP_W-1:0]       qc_q, qc_d;
  logic [PAGE_IDX_W-1:0] page_q, page_d;
  logic [PAGE_IDX_W-1:0] page_end_q, page_end_d;
  logic [WORD_SEL_W-1:0] word_q, word_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic                  fresh_q, fresh_d;
  logic                  res_member_q, res_member_d;
  logic                  res_status_q, res_status_d;
  logic                  out_member_q, out_member_d;
  logic                  out_status_q, out_status_d;

  // Memory ports.
  logic [SLOT_W-1:0]     pm_mem [PAGE_COUNT];
  logic                  pm_we;
  logic [PAGE_W-1:0]     pm_addr;
  logic [SLOT_W-1:0]     pm_wdata;
  logic [SLOT_W-1:0]     pm_rdata_q;
  logic [WORD_W-1:0]     bm_mem [BM_DEPTH];
  logic                  bm_we;
  logic [BM_AW-1:0]      bm_addr;
  logic [WORD_W-1:0]     bm_wdata;
  logic [WORD_W-1:0]     bm_rdata_q;

  word_req_t             mask_req;
  logic [WORD_W-1:0]     mask;
  logic [PAGE_IDX_W-1:0] q_page;
  logic                  q_miss;
  logic [SLOT_W-1:0]     next_slot;

  // The one mask unit serves every word of every page an add reaches.
  assign mask_req = '{first: first_q, last: last_q, page: page_q, word: word_q};

  tlbcc_mask_unit u_mask (
    .req_i  (mask_req),
    .mask_o (mask)
  );

  assign q_page    = qc_q[CP_W-1:OFFSET_SHIFT];
  assign q_miss    = !any_q || ({1'b0, q_page} >= PageLimit) ||
                     (q_page < low_q) || (q_page > high_q);
  assign next_slot = used_q + 1'b1;

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.is_member = out_member_q;
  assign out_o.status    = out_status_q;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    low_d        = low_q;
    high_d       = high_q;
    any_d        = any_q;
    clr_ptr_d    = clr_ptr_q;
    clr_end_d    = clr_end_q;
    clr_reply_d  = clr_reply_q;
    out_valid_d  = out_valid_q;
    first_d      = first_q;
    last_d       = last_q;
    qc_d         = qc_q;
    page_d       = page_q;
    page_end_d   = page_end_q;
    word_d       = word_q;
    slot_d       = slot_q;
    fresh_d      = fresh_q;
    res_member_d = res_member_q;
    res_status_d = res_status_q;
    out_member_d = out_member_q;
    out_status_d = out_status_q;
    pm_we        = 1'b0;
    pm_addr      = page_q[PAGE_W-1:0];
    pm_wdata     = '0;
    bm_we        = 1'b0;
    bm_addr      = {slot_q, word_q};
    bm_wdata     = fresh_q ? mask : (bm_rdata_q | mask);

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          first_d      = in_i.range_first;
          last_d       = in_i.range_last;
          qc_d         = in_i.query_char;
          res_member_d = 1'b0;
          res_status_d = 1'b0;
          case (in_i.op)
            OP_CLEAR: begin
              used_d = '0;
              low_d  = '0;
              high_d = '0;
              any_d  = 1'b0;
              // Only pages inside the written span can hold a bitmap.
              if (any_q) begin
                clr_ptr_d   = low_q;
                clr_end_d   = high_q;
                clr_reply_d = 1'b1;
                state_d     = S_CLR;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_ADD: begin
              page_d     = in_i.range_first[CP_W-1:OFFSET_SHIFT];
              page_end_d = in_i.range_last[CP_W-1:OFFSET_SHIFT];
              state_d    = (in_i.range_last < in_i.range_first) ? S_DONE : S_ADD_PM;
            end
            OP_QUERY: begin
              state_d = S_Q_PM;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Zero one page map entry per cycle.
      S_CLR: begin
        pm_we   = 1'b1;
        pm_addr = clr_ptr_q[PAGE_W-1:0];
        if (clr_ptr_q == clr_end_q) begin
          state_d = clr_reply_q ? S_DONE : S_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end

      // Read the page map entry; pages past the tracked count end the add.
      S_ADD_PM: begin
        state_d = ({1'b0, page_q} >= PageLimit) ? S_DONE : S_ADD_CHK;
      end

      // Reuse the page's bitmap or allocate the next free one; a full store ends the add with status set.
      S_ADD_CHK: begin
        if (pm_rdata_q == '0 && used_q == UsedMax) begin
          res_status_d = 1'b1;
          state_d      = S_DONE;
        end else begin
          if (pm_rdata_q == '0) begin
            used_d   = next_slot;
            slot_d   = next_slot;
            pm_we    = 1'b1;
            pm_wdata = next_slot;
            fresh_d  = 1'b1;
          end else begin
            slot_d  = pm_rdata_q;
            fresh_d = 1'b0;
          end
          if (!any_q || page_q < low_q) begin
            low_d = page_q;
          end
          if (!any_q || page_q > high_q) begin
            high_d = page_q;
          end
          any_d   = 1'b1;
          word_d  = '0;
          state_d = S_ADD_RD;
        end
      end

      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end

      // A fresh bitmap is overwritten, so its old contents never show.
      S_ADD_WR: begin
        bm_we = 1'b1;
        if (word_q == WORD_LAST) begin
          if (page_q == page_end_q) begin
            state_d = S_DONE;
          end else begin
            page_d  = page_q + 1'b1;
            state_d = S_ADD_PM;
          end
        end else begin
          word_d  = word_q + 1'b1;
          state_d = S_ADD_RD;
        end
      end

      S_Q_PM: begin
        pm_addr = q_page[PAGE_W-1:0];
        state_d = q_miss ? S_DONE : S_Q_BM;
      end

      // Bitmap zero is never written and answers empty.
      S_Q_BM: begin
        bm_addr = {pm_rdata_q, qc_q[OFFSET_SHIFT-1:BITSET_SHIFT]};
        state_d = (pm_rdata_q == '0) ? S_DONE : S_Q_BIT;
      end

      S_Q_BIT: begin
        res_member_d = bm_rdata_q[qc_q[BIT_SEL_W-1:0]];
        state_d      = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_member_d = res_member_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the page map sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      used_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      any_q       <= 1'b0;
      clr_ptr_q   <= '0;
      clr_end_q   <= PageMax;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      low_q       <= low_d;
      high_q      <= high_d;
      any_q       <= any_d;
      clr_ptr_q   <= clr_ptr_d;
      clr_end_q   <= clr_end_d;
      clr_reply_q <= clr_reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    last_q       <= last_d;
    qc_q         <= qc_d;
    page_q       <= page_d;
    page_end_q   <= page_end_d;
    word_q       <= word_d;
    slot_q       <= slot_d;
    fresh_q      <= fresh_d;
    res_member_q <= res_member_d;
    res_status_q <= res_status_d;
    out_member_q <= out_member_d;
    out_status_q <= out_status_d;
  end

  // Page map memory, one port, registered read.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm_mem[pm_addr] <= pm_wdata;
    end
    pm_rdata_q <= pm_mem[pm_addr];
  end

  // Bitmap word memory, one port, registered read.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_addr] <= bm_wdata;
    end
    bm_rdata_q <= bm_mem[bm_addr];
  end
endmodule
